// File: sv/assert_macros.svh
// Assertion macros shared by the record parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, idle while reset is applied.
`define MDVRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define MDVRP_NEVER(label, cond, msg) \
    `MDVRP_ASSERT(label, !(cond), msg)

`endif

// File: sv/mdvrp_pkg.sv
// Shared types, codes and tables for the M-Bus record parser.
package mdvrp_pkg;

    // Saturation limit of the byte position within one telegram.
    localparam logic [7:0] MAX_TELEGRAM_BYTES = 8'd255;

    // Depth of the queue between the decode front and the parse back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Byte values and marker lengths.
    localparam logic [7:0] FILLER_BYTE  = 8'h2F;
    localparam logic [7:0] LEN_VARIABLE = 8'hFE;
    localparam logic [7:0] LEN_SPECIAL  = 8'hFF;

    // Byte class codes.
    localparam logic [2:0] CLS_FILLER  = 3'd0;
    localparam logic [2:0] CLS_DIF     = 3'd1;
    localparam logic [2:0] CLS_DIFE    = 3'd2;
    localparam logic [2:0] CLS_VIF     = 3'd3;
    localparam logic [2:0] CLS_VIFE    = 3'd4;
    localparam logic [2:0] CLS_LEN     = 3'd5;
    localparam logic [2:0] CLS_DATA    = 3'd6;
    localparam logic [2:0] CLS_IGNORED = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_CUT     = 2'd3;

    // One byte after decode, as it waits in the queue.
    typedef struct packed {
        logic [7:0] byte_value;
        logic [3:0] nibble;
        logic [7:0] dif_len;
        logic [7:0] after;
        logic       is_last;
        logic       left_gt2;
        logic       is_filler;
        logic       ext;
    } pre_t;

    // Data length for each DIF low nibble.
    function automatic logic [7:0] dif_len_lookup(input logic [3:0] nib);
        logic [7:0] len;
        case (nib)
            4'h0:    len = 8'd0;
            4'h1:    len = 8'd1;
            4'h2:    len = 8'd2;
            4'h3:    len = 8'd3;
            4'h4:    len = 8'd4;
            4'h5:    len = 8'd4;
            4'h6:    len = 8'd6;
            4'h7:    len = 8'd8;
            4'h8:    len = 8'd0;
            4'h9:    len = 8'd1;
            4'hA:    len = 8'd2;
            4'hB:    len = 8'd3;
            4'hC:    len = 8'd4;
            4'hD:    len = LEN_VARIABLE;
            4'hE:    len = 8'd6;
            default: len = LEN_SPECIAL;
        endcase
        return len;
    endfunction

endpackage

// File: sv/mdvrp_if.sv
// Handshake channels of the record parser: telegram bytes, results and configuration.
interface mdvrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic [7:0] bytes_left;

    modport source (output valid, output byte_value, output bytes_left, input ready);
    modport sink   (input valid, input byte_value, input bytes_left, output ready);
endinterface

interface mdvrp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] byte_class;
    logic [7:0] record_index;
    logic [3:0] data_type;
    logic [7:0] record_length;
    logic [8:0] byte_offset;
    logic       last_of_record;
    logic [1:0] status;

    modport source (output valid, output byte_class, output record_index,
                    output data_type, output record_length, output byte_offset,
                    output last_of_record, output status, input ready);
    modport sink   (input valid, input byte_class, input record_index,
                    input data_type, input record_length, input byte_offset,
                    input last_of_record, input status, output ready);
endinterface

interface mdvrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_offset;

    modport source (output valid, output start_offset, input ready);
    modport sink   (input valid, input start_offset, output ready);
endinterface

// File: sv/mbus_dif_vif_record_parser.sv
// Top level of the M-Bus DIF/VIF data record parser.
// Usage:
//   telegram: one application byte per transfer, with the count of bytes left
//     including this one; a count of 1 (or 0) marks the last byte.
//   result: one transfer per input byte carrying its class, record index,
//     data type, clamped record length, telegram offset, record end flag
//     and status.
//   cfg: writes start_offset; ready is always high. Write only while idle.
// Path: a transferred byte is written into the queue, then parsed into the
//   result register once that register is empty or being drained.
// Throughput: one byte per cycle while the result is taken, set by the combinational parse step in the
//   back end; a four-entry queue decouples the input from the result side.
// Reset: all parse state clears, start_offset returns to 0, the queue empties.
// Stall: while the result is not taken, the back end holds it and the queue
//   fills; telegram ready drops once the queue is full.
module mbus_dif_vif_record_parser
    import mdvrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mdvrp_in_if.sink    telegram,
    mdvrp_out_if.source result,
    mdvrp_cfg_if.sink   cfg
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    pre_t pre;
    pre_t q_data;

    // Byte decode and input handshake.
    mdvrp_front u_front (
        .telegram (telegram),
        .q_full   (q_full),
        .push     (push),
        .pre      (pre)
    );

    // Queue between decode and parse.
    mdvrp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (pre),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Record state machine and result register.
    mdvrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .pop     (pop),
        .result  (result),
        .cfg     (cfg)
    );

endmodule

// File: sv/mdvrp_front.sv
// Decode front: accepts telegram bytes and classifies each into a queue entry.
module mdvrp_front
    import mdvrp_pkg::*;
(
    mdvrp_in_if.sink telegram,
    input  logic     q_full,
    output logic     push,
    output pre_t     pre
);

    logic [7:0] left;

    // A transfer happens whenever the queue has room.
    assign telegram.ready = !q_full;
    assign push           = telegram.valid && !q_full;

    // A count of zero bytes left is treated as the last byte.
    assign left = (telegram.bytes_left == 8'd0) ? 8'd1 : telegram.bytes_left;

    // Per-byte decode that does not depend on parser state.
    always_comb
    begin
        pre.byte_value = telegram.byte_value;
        pre.nibble     = telegram.byte_value[3:0];
        pre.dif_len    = dif_len_lookup(telegram.byte_value[3:0]);
        pre.after      = left - 8'd1;
        pre.is_last    = (left == 8'd1);
        pre.left_gt2   = (left > 8'd2);
        pre.is_filler  = (telegram.byte_value == FILLER_BYTE);
        pre.ext        = telegram.byte_value[7];
    end

endmodule

// File: sv/mdvrp_fifo.sv
// Short queue of decoded bytes between the front and the parse back end.
`include "assert_macros.svh"
module mdvrp_fifo
    import mdvrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pre_t push_data,
    output logic full,
    input  logic pop,
    output pre_t pop_data,
    output logic empty
);

    pre_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `MDVRP_ASSERT(a_no_overflow, (push && !pop) |-> (count_reg < Q_CNT_W'(Q_DEPTH)), "queue overflow")
    `MDVRP_NEVER(a_no_underflow, pop && (count_reg == '0), "pop from empty queue")

endmodule

// File: sv/mdvrp_back.sv
// Parse back end: walks the DIF/VIF record state and registers one result per byte.
`include "assert_macros.svh"
module mdvrp_back
    import mdvrp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pre_t          q_data,
    output logic          pop,
    mdvrp_out_if.source   result,
    mdvrp_cfg_if.sink     cfg
);

    typedef enum logic [2:0] {
        PH_DIF,
        PH_DIFE,
        PH_VIF,
        PH_VIFE,
        PH_LEN,
        PH_DATA
    } phase_t;

    // Parser state.
    phase_t     phase_reg, phase_next;
    logic [7:0] data_left_reg, data_left_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] position_reg, position_next;
    logic [3:0] type_reg, type_next;
    logic       varlen_reg, varlen_next;
    logic       stopped_reg, stopped_next;
    logic [7:0] rec_len_reg, rec_len_next;
    logic [7:0] want_reg, want_next;
    logic [7:0] start_offset_reg;

    // Result register.
    logic       out_valid_reg;
    logic [2:0] cls_reg, cls_next;
    logic [7:0] idx_reg;
    logic [3:0] dtype_reg, dtype_next;
    logic [7:0] rlen_reg, rlen_next;
    logic [8:0] off_reg, off_next;
    logic       last_reg, last_next;
    logic [1:0] st_reg, st_next;

    // Helpers for the shared data-start and record-end steps.
    logic       bd_en;
    logic [7:0] bd_want;
    logic [7:0] bd_len;
    logic       er_en;
    logic [7:0] dl_dec;

    // A new byte enters when the result register is empty or being drained.
    assign pop       = !q_empty && (!out_valid_reg || result.ready);
    assign cfg.ready = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.byte_class     = cls_reg;
    assign result.record_index   = idx_reg;
    assign result.data_type      = dtype_reg;
    assign result.record_length  = rlen_reg;
    assign result.byte_offset    = off_reg;
    assign result.last_of_record = last_reg;
    assign result.status         = st_reg;

    assign off_next = {1'b0, start_offset_reg} + {1'b0, position_reg};
    assign dl_dec   = (data_left_reg != 8'd0) ? (data_left_reg - 8'd1) : 8'd0;

    // Next state and result for the byte at the head of the queue.
    always_comb
    begin
        phase_next     = phase_reg;
        data_left_next = data_left_reg;
        count_next     = count_reg;
        position_next  = position_reg;
        type_next      = type_reg;
        varlen_next    = varlen_reg;
        stopped_next   = stopped_reg;
        rec_len_next   = rec_len_reg;
        want_next      = want_reg;
        cls_next       = CLS_IGNORED;
        dtype_next     = type_reg;
        rlen_next      = rec_len_reg;
        last_next      = 1'b0;
        st_next        = ST_OK;
        bd_en          = 1'b0;
        bd_want        = 8'd0;
        bd_len         = 8'd0;
        er_en          = 1'b0;

        if (stopped_reg)
        begin
            st_next   = ST_STOPPED;
            rlen_next = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_DIF:
                begin
                    if (q_data.is_filler)
                    begin
                        cls_next   = CLS_FILLER;
                        dtype_next = 4'd0;
                        rlen_next  = 8'd0;
                    end
                    else
                    begin
                        cls_next     = CLS_DIF;
                        type_next    = q_data.nibble;
                        dtype_next   = q_data.nibble;
                        rec_len_next = 8'd0;
                        rlen_next    = 8'd0;
                        if (q_data.dif_len == LEN_SPECIAL)
                        begin
                            stopped_next = 1'b1;
                            st_next      = ST_STOPPED;
                        end
                        else
                        begin
                            varlen_next = (q_data.dif_len == LEN_VARIABLE);
                            want_next   = q_data.dif_len;
                            phase_next  = q_data.ext ? PH_DIFE : PH_VIF;
                            if (q_data.is_last)
                            begin
                                st_next   = ST_CUT;
                                last_next = 1'b1;
                            end
                        end
                    end
                end
                PH_DIFE:
                begin
                    cls_next = CLS_DIFE;
                    if (!q_data.ext)
                    begin
                        phase_next = PH_VIF;
                    end
                    if (q_data.is_last)
                    begin
                        st_next   = ST_CUT;
                        last_next = 1'b1;
                    end
                end
                PH_VIF, PH_VIFE:
                begin
                    cls_next = (phase_reg == PH_VIF) ? CLS_VIF : CLS_VIFE;
                    if (q_data.ext)
                    begin
                        phase_next = PH_VIFE;
                        if (q_data.is_last)
                        begin
                            st_next   = ST_CUT;
                            last_next = 1'b1;
                        end
                    end
                    else if (varlen_reg)
                    begin
                        // Variable length needs room for its length byte.
                        if (q_data.after == 8'd0)
                        begin
                            st_next   = ST_CUT;
                            last_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    else
                    begin
                        bd_en   = 1'b1;
                        bd_want = want_reg;
                    end
                end
                PH_LEN:
                begin
                    // A short tail overrides the length byte value.
                    cls_next = CLS_LEN;
                    bd_en    = 1'b1;
                    bd_want  = q_data.left_gt2 ? q_data.byte_value : q_data.after;
                end
                PH_DATA:
                begin
                    cls_next       = CLS_DATA;
                    data_left_next = dl_dec;
                    if (dl_dec == 8'd0)
                    begin
                        er_en = 1'b1;
                    end
                    else if (q_data.is_last)
                    begin
                        st_next   = ST_TRUNC;
                        last_next = 1'b1;
                    end
                end
                default:
                begin
                    cls_next   = CLS_IGNORED;
                    phase_next = PH_DIF;
                    rlen_next  = 8'd0;
                end
            endcase
        end

        // Start of the data part, clamped to the bytes that remain.
        if (bd_en)
        begin
            if (bd_want > q_data.after)
            begin
                bd_len  = q_data.after;
                st_next = ST_TRUNC;
            end
            else
            begin
                bd_len = bd_want;
            end
            rec_len_next = bd_len;
            rlen_next    = bd_len;
            if (bd_len == 8'd0)
            begin
                er_en = 1'b1;
            end
            else
            begin
                phase_next     = PH_DATA;
                data_left_next = bd_len;
            end
        end

        // End of the current record.
        if (er_en)
        begin
            last_next      = 1'b1;
            count_next     = (count_reg != 8'hFF) ? (count_reg + 8'd1) : count_reg;
            phase_next     = PH_DIF;
            data_left_next = 8'd0;
        end

        // The last byte of a telegram returns the parser to its reset state.
        if (q_data.is_last)
        begin
            phase_next     = PH_DIF;
            data_left_next = 8'd0;
            count_next     = 8'd0;
            position_next  = 8'd0;
            type_next      = 4'd0;
            varlen_next    = 1'b0;
            stopped_next   = 1'b0;
            rec_len_next   = 8'd0;
            want_next      = 8'd0;
        end
        else if (position_reg < MAX_TELEGRAM_BYTES)
        begin
            position_next = position_reg + 8'd1;
        end
    end

    // State, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_DIF;
            data_left_reg    <= 8'd0;
            count_reg        <= 8'd0;
            position_reg     <= 8'd0;
            type_reg         <= 4'd0;
            varlen_reg       <= 1'b0;
            stopped_reg      <= 1'b0;
            rec_len_reg      <= 8'd0;
            want_reg         <= 8'd0;
            start_offset_reg <= 8'd0;
            out_valid_reg    <= 1'b0;
            cls_reg          <= CLS_IGNORED;
            idx_reg          <= 8'd0;
            dtype_reg        <= 4'd0;
            rlen_reg         <= 8'd0;
            off_reg          <= 9'd0;
            last_reg         <= 1'b0;
            st_reg           <= ST_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                start_offset_reg <= cfg.start_offset;
            end
            if (pop)
            begin
                phase_reg     <= phase_next;
                data_left_reg <= data_left_next;
                count_reg     <= count_next;
                position_reg  <= position_next;
                type_reg      <= type_next;
                varlen_reg    <= varlen_next;
                stopped_reg   <= stopped_next;
                rec_len_reg   <= rec_len_next;
                want_reg      <= want_next;
                out_valid_reg <= 1'b1;
                cls_reg       <= cls_next;
                idx_reg       <= count_reg;
                dtype_reg     <= dtype_next;
                rlen_reg      <= rlen_next;
                off_reg       <= off_next;
                last_reg      <= last_next;
                st_reg        <= st_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `MDVRP_ASSERT(a_stop_in_dif, stopped_reg |-> (phase_reg == PH_DIF), "stopped outside DIF phase")
    `MDVRP_ASSERT(a_left_in_data, (data_left_reg != 8'd0) |-> (phase_reg == PH_DATA), "data count outside data phase")
    `MDVRP_NEVER(a_no_overwrite, pop && out_valid_reg && !result.ready, "result overwritten while stalled")

endmodule
